// ===== src/ubuf_pkg.sv =====
// ----------------------------------------------------------------------------
// ubuf_pkg: shared types and constants for the buffered UART rings
// Event kinds, word layout and the control and status structs of one ring.
// ----------------------------------------------------------------------------
package ubuf_pkg;

  localparam int BYTE_W       = 8;
  localparam int RX_DEPTH_DEF = 64;
  localparam int TX_DEPTH_DEF = 64;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam int OUT_LINE_VALID = 0;
  localparam int OUT_LINE_BYTE  = 1;
  localparam int OUT_READ_VALID = 9;
  localparam int OUT_READ_BYTE  = 10;
  localparam int OUT_DROPPED    = 18;
  localparam int OUT_CLEARED    = 19;

  typedef enum logic [1:0] {
    KIND_LINE_RX = 2'd0,
    KIND_TX_DONE = 2'd1,
    KIND_PUT     = 2'd2,
    KIND_GET     = 2'd3
  } kind_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [BYTE_W-1:0] head;
  } ring_stat_t;

endpackage

// ===== src/ubuf_cell.sv =====
// ----------------------------------------------------------------------------
// ubuf_cell: one storage cell of a ring
// Holds one byte; on a pop it takes its neighbor's byte, on a push the first
// empty cell loads the new byte.
// ----------------------------------------------------------------------------
module ubuf_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  ubuf_pkg::ring_cmd_t       cmd,
  input  logic [ubuf_pkg::BYTE_W-1:0] din,
  input  logic                      prev_valid,
  input  logic                      next_valid,
  input  logic [ubuf_pkg::BYTE_W-1:0] next_data,
  output logic                      valid,
  output logic [ubuf_pkg::BYTE_W-1:0] data
);
  import ubuf_pkg::*;

  logic              valid_next;
  logic [BYTE_W-1:0] data_next;

  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (cmd.push && cmd.pop) begin
      if (valid) begin
        data_next = next_valid ? next_data : din;
      end
    end else if (cmd.pop) begin
      valid_next = next_valid;
      data_next  = next_data;
    end else if (cmd.push) begin
      if (!valid && prev_valid) begin
        valid_next = 1'b1;
        data_next  = din;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== src/ubuf_ring.sv =====
// ----------------------------------------------------------------------------
// ubuf_ring: byte queue built as a row of shifting cells
// Holds up to DEPTH-1 bytes; the oldest byte always sits in the first cell.
// ----------------------------------------------------------------------------
module ubuf_ring #(
  parameter int DEPTH = ubuf_pkg::RX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ubuf_pkg::ring_cmd_t         cmd,
  input  logic [ubuf_pkg::BYTE_W-1:0] din,
  output ubuf_pkg::ring_stat_t        stat
);
  import ubuf_pkg::*;

  localparam int CELLS = DEPTH - 1;

  logic [CELLS:0]    vld;
  logic [BYTE_W-1:0] dat [CELLS:0];

  assign vld[CELLS] = 1'b0;
  assign dat[CELLS] = '0;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic prev_v;
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_rest
      assign prev_v = vld[i-1];
    end
    ubuf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .din        (din),
      .prev_valid (prev_v),
      .next_valid (vld[i+1]),
      .next_data  (dat[i+1]),
      .valid      (vld[i]),
      .data       (dat[i])
    );
  end

  assign stat.empty = !vld[0];
  assign stat.full  = vld[CELLS-1];
  assign stat.head  = dat[0];

endmodule

// ===== src/uart_rx_tx_ring_buffers.sv =====
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers: buffered UART with receive and transmit rings
// Handles line bytes, transmit-complete events, host puts and host gets.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word contents
//  s_axis   in   tuser: kind; tdata: data, tx_empty
//  m_axis   out  tdata: line_valid, line_byte, read_valid, read_byte,
//                dropped, complete_cleared
//
// One event is taken per cycle; its result appears in the output register
// on the next cycle. The rings are rows of shifting cells, so every event is
// finished in the cycle it is accepted. Reset empties both rings at once.
// The input is stalled only while a result waits and m_tready is low.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers #(
  parameter int RX_DEPTH = ubuf_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = ubuf_pkg::TX_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] data, [8] tx_empty
  input  logic [ubuf_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [1:0] kind
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
  // [18] dropped, [19] complete_cleared
  output logic [ubuf_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ubuf_pkg::*;

  logic              accept;
  kind_t             kind;
  logic [BYTE_W-1:0] in_byte;
  logic              tx_empty;
  ring_cmd_t         rx_cmd;
  ring_cmd_t         tx_cmd;
  ring_stat_t        rx_stat;
  ring_stat_t        tx_stat;
  logic              line_valid;
  logic [BYTE_W-1:0] line_byte;
  logic              read_valid;
  logic [BYTE_W-1:0] read_byte;
  logic              dropped;
  logic              cleared;
  logic [OUT_TDATA_W-1:0] result;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign kind     = kind_t'(s_tuser);
  assign in_byte  = s_tdata[BYTE_W-1:0];
  assign tx_empty = s_tdata[BYTE_W];

  always_comb begin
    rx_cmd     = '0;
    tx_cmd     = '0;
    line_valid = 1'b0;
    line_byte  = '0;
    read_valid = 1'b0;
    read_byte  = '0;
    dropped    = 1'b0;
    cleared    = 1'b0;
    case (kind)
      KIND_LINE_RX: begin
        if (rx_stat.full) begin
          dropped = 1'b1;
        end else begin
          rx_cmd.push = 1'b1;
        end
      end
      KIND_TX_DONE: begin
        if (tx_stat.empty) begin
          cleared = 1'b1;
        end else begin
          line_valid = 1'b1;
          line_byte  = tx_stat.head;
          tx_cmd.pop = 1'b1;
        end
      end
      KIND_PUT: begin
        if (tx_stat.full) begin
          dropped = 1'b1;
        end else if (tx_empty) begin
          line_valid = 1'b1;
          if (tx_stat.empty) begin
            line_byte = in_byte;
          end else begin
            line_byte   = tx_stat.head;
            tx_cmd.push = 1'b1;
            tx_cmd.pop  = 1'b1;
          end
        end else begin
          tx_cmd.push = 1'b1;
        end
      end
      KIND_GET: begin
        if (!rx_stat.empty) begin
          read_valid = 1'b1;
          read_byte  = rx_stat.head;
          rx_cmd.pop = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      rx_cmd = '0;
      tx_cmd = '0;
    end
  end

  assign result = {4'b0, cleared, dropped, read_byte, read_valid, line_byte, line_valid};

  ubuf_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (rx_cmd),
    .din  (in_byte),
    .stat (rx_stat)
  );

  ubuf_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (tx_cmd),
    .din  (in_byte),
    .stat (tx_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result;
    end
  end

endmodule

// ===== src/ubuf_checker.sv =====
// ----------------------------------------------------------------------------
// ubuf_checker: port-level checks for the buffered UART rings
// Watches the stream ports of the top level and is bound to it.
// ----------------------------------------------------------------------------
module ubuf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [1:0]                       s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ubuf_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ubuf_pkg::*;

  logic in_acc;
  assign in_acc = s_tvalid && s_tready;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output word changed.");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled with an empty output register.");

  a_result: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> m_tvalid)
    else $error("Accepted word produced no result.");

  a_get: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tuser == KIND_GET |=>
      !m_tdata[OUT_LINE_VALID] && !m_tdata[OUT_DROPPED] && !m_tdata[OUT_CLEARED])
    else $error("Host get reported a transmit or drop flag.");

  a_done: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tuser == KIND_TX_DONE |=>
      m_tdata[OUT_LINE_VALID] != m_tdata[OUT_CLEARED])
    else $error("Transmit complete must either send a byte or clear.");

endmodule

bind uart_rx_tx_ring_buffers ubuf_checker u_ubuf_checker (.*);
